>>> rtl/core/tccw_pkg.sv
// Package for the text console cursor writer: screen geometry, field widths,
// control character codes and the structs passed between the core modules.
// Depends on nothing; every other file of the block imports it.
package tccw_pkg;

	localparam int SCREEN_WIDTH  = 80;
	localparam int SCREEN_HEIGHT = 25;
	localparam int TAB_STOP      = 8;

	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int CHAR_W  = 8;
	localparam int ATTR_W  = 8;
	localparam int IDX_W   = 11;
	localparam int VAL_W   = 16;
	localparam int WIDE_W  = 8;
	localparam int PROD_W  = 13;

	localparam logic [ATTR_W-1:0] TEXT_COLOR_RESET = 8'h07;

	localparam logic CMD_PUT = 1'b0;
	localparam logic CMD_SET = 1'b1;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;

	typedef struct packed {
		logic              cmd;
		logic [CHAR_W-1:0] char_code;
		logic [COL_W-1:0]  new_col;
		logic [ROW_W-1:0]  new_row;
	} tccw_cmd_t;

	typedef struct packed {
		logic             write_enable;
		logic [IDX_W-1:0] cell_index;
		logic [VAL_W-1:0] cell_value;
		logic [COL_W-1:0] cursor_col;
		logic [ROW_W-1:0] cursor_row;
	} tccw_result_t;

endpackage

>>> rtl/core/tccw_cursor_logic.sv
// Combinational cursor update and cell write for one command.
// Depends on tccw_pkg for geometry, character codes and the command/result structs.
module tccw_cursor_logic
	import tccw_pkg::*;
(
	input  tccw_cmd_t          command,
	input  logic [COL_W-1:0]   cur_col,
	input  logic [ROW_W-1:0]   cur_row,
	input  logic [ATTR_W-1:0]  text_color,
	output tccw_result_t       result
);

	logic [WIDE_W-1:0] col_inc;
	logic [WIDE_W-1:0] col_tab;
	logic [WIDE_W-1:0] row_inc;
	logic [ROW_W-1:0]  row_next_line;
	logic [PROD_W-1:0] prod;

	assign col_inc = WIDE_W'(cur_col) + WIDE_W'(1);
	assign col_tab = (WIDE_W'(cur_col) + WIDE_W'(TAB_STOP)) & ~WIDE_W'(TAB_STOP - 1);
	assign row_inc = WIDE_W'(cur_row) + WIDE_W'(1);
	assign row_next_line = (row_inc >= WIDE_W'(SCREEN_HEIGHT)) ? '0 : row_inc[ROW_W-1:0];
	assign prod = PROD_W'(cur_row) * PROD_W'(SCREEN_WIDTH) + PROD_W'(cur_col);

	always_comb begin
		result.write_enable = 1'b0;
		result.cell_index   = '0;
		result.cell_value   = '0;
		result.cursor_col   = cur_col;
		result.cursor_row   = cur_row;
		if (command.cmd == CMD_SET) begin
			result.cursor_col = (WIDE_W'(command.new_col) > WIDE_W'(SCREEN_WIDTH - 1)) ?
				COL_W'(SCREEN_WIDTH - 1) : command.new_col;
			result.cursor_row = (WIDE_W'(command.new_row) > WIDE_W'(SCREEN_HEIGHT - 1)) ?
				ROW_W'(SCREEN_HEIGHT - 1) : command.new_row;
		end else begin
			case (command.char_code)
				CH_BACKSPACE: begin
					if (cur_col != '0) begin
						result.cursor_col = cur_col - COL_W'(1);
					end
				end
				CH_TAB: begin
					if (col_tab >= WIDE_W'(SCREEN_WIDTH)) begin
						result.cursor_col = '0;
						result.cursor_row = row_next_line;
					end else begin
						result.cursor_col = col_tab[COL_W-1:0];
					end
				end
				CH_CR: begin
					result.cursor_col = '0;
				end
				CH_LF: begin
					result.cursor_col = '0;
					result.cursor_row = row_next_line;
				end
				default: begin
					result.write_enable = 1'b1;
					result.cell_index   = prod[IDX_W-1:0];
					result.cell_value   = {text_color, command.char_code};
					if (col_inc >= WIDE_W'(SCREEN_WIDTH)) begin
						result.cursor_col = '0;
						result.cursor_row = row_next_line;
					end else begin
						result.cursor_col = col_inc[COL_W-1:0];
					end
				end
			endcase
		end
	end

endmodule

>>> rtl/core/text_console_cursor_writer.sv
// Top level of the text console cursor writer: input register, cursor state,
// color register and result register. Depends on tccw_pkg and tccw_cursor_logic.
// A command is taken into the input register, updated by the cursor logic and presented from the result register.
// Throughput: one command per cycle while out_stall is low, set by the single cursor update stage.
// Reset: arst_n clears both valid flags and the cursor to column 0, row 0,
// and loads the text color with 7.
module text_console_cursor_writer
	import tccw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              cmd,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [COL_W-1:0]  new_col,
	input  logic [ROW_W-1:0]  new_row,
	input  logic              cfg_we,
	input  logic [ATTR_W-1:0] cfg_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              write_enable,
	output logic [IDX_W-1:0]  cell_index,
	output logic [VAL_W-1:0]  cell_value,
	output logic [COL_W-1:0]  cursor_col,
	output logic [ROW_W-1:0]  cursor_row
);

	logic         valid_s1;
	tccw_cmd_t    cmd_s1;
	logic         valid_s2;
	tccw_result_t result_s2;
	tccw_result_t result_next;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ATTR_W-1:0] text_color_q;
	logic advance;
	logic take_in;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	tccw_cursor_logic u_cursor_logic (
		.command    (cmd_s1),
		.cur_col    (col_q),
		.cur_row    (row_q),
		.text_color (text_color_q),
		.result     (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			col_q        <= '0;
			row_q        <= '0;
			text_color_q <= TEXT_COLOR_RESET;
		end else begin
			if (cfg_we) begin
				text_color_q <= cfg_data;
			end
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				col_q    <= result_next.cursor_col;
				row_q    <= result_next.cursor_row;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			cmd_s1 <= '{cmd: cmd, char_code: char_code, new_col: new_col, new_row: new_row};
		end
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	assign out_valid    = valid_s2;
	assign write_enable = result_s2.write_enable;
	assign cell_index   = result_s2.cell_index;
	assign cell_value   = result_s2.cell_value;
	assign cursor_col   = result_s2.cursor_col;
	assign cursor_row   = result_s2.cursor_row;

	assert property (@(posedge clk) disable iff (!arst_n)
		WIDE_W'(col_q) < WIDE_W'(SCREEN_WIDTH) && WIDE_W'(row_q) < WIDE_W'(SCREEN_HEIGHT))
		else $error("Cursor left the screen.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> cell_index == '0 && cell_value == '0)
		else $error("Result without a cell write carries a nonzero cell.");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> col_q == cursor_col && row_q == cursor_row)
		else $error("Cursor state differs from the presented result.");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("Input stalled without a full pipeline.");

endmodule
